// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker in rtl/rpc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define RPC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every rising clock edge while reset is held.
`define RPC_ASSERT_IN_RESET(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`endif

// ===== rtl/rpc_pkg.sv =====
package rpc_pkg;

  localparam int ElemW = 4;
  localparam int QueueDepth = 2;

  typedef logic [ElemW-1:0] elem_t;

  typedef struct packed {
    logic  pair_valid;
    elem_t first_elem;
    elem_t second_elem;
    logic  last;
  } in_item_t;

  typedef struct packed {
    logic is_symmetric;
    logic is_antisymmetric;
    logic is_transitive;
  } out_item_t;

  typedef struct packed {
    logic  set_bit;
    elem_t first_elem;
    elem_t second_elem;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    StRun   = 3'b001,
    StSweep = 3'b010,
    StDone  = 3'b100
  } back_state_e;

endpackage

// ===== rtl/rpc_front.sv =====
module rpc_front import rpc_pkg::*; #(
  parameter int ELEMENTS = 16
) (
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  input  q_status_t q_status_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic first_ok;
  logic second_ok;

  // A pair with an index outside the relation is dropped.
  assign first_ok  = 32'(in_item_i.first_elem) < ELEMENTS;
  assign second_ok = 32'(in_item_i.second_elem) < ELEMENTS;

  assign cmd_o.set_bit     = in_item_i.pair_valid & first_ok & second_ok;
  assign cmd_o.first_elem  = in_item_i.first_elem;
  assign cmd_o.second_elem = in_item_i.second_elem;
  assign cmd_o.last        = in_item_i.last;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full & (cmd_o.set_bit | cmd_o.last);

endmodule

// ===== rtl/rpc_queue.sv =====
module rpc_queue import rpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output cmd_t      cmd_o,
  output q_status_t status_o
);

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = count_q == (PtrW+1)'(QueueDepth);
  assign status_o.empty = count_q == '0;
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/rpc_back.sv =====
module rpc_back import rpc_pkg::*; #(
  parameter int ELEMENTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  localparam int IdxW = $clog2(ELEMENTS);

  back_state_e         state_q, state_d;
  logic [ELEMENTS-1:0] mat_q [ELEMENTS];
  logic [ELEMENTS-1:0] mat_d [ELEMENTS];
  logic [IdxW-1:0]     cnt_q, cnt_d;
  out_item_t           flags_q, flags_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic [ELEMENTS-1:0] row_a;
  logic [ELEMENTS-1:0] col_a;
  logic [ELEMENTS-1:0] diag;
  logic                trans_miss;
  logic                out_free;
  logic [IdxW-1:0]     row_idx;
  logic [IdxW-1:0]     col_idx;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign pop_o       = (state_q == StRun) & ~q_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign row_idx     = IdxW'(cmd_i.first_elem);
  assign col_idx     = IdxW'(cmd_i.second_elem);

  // One row of the matrix is checked per cycle of the sweep.
  always_comb begin
    row_a      = mat_q[cnt_q];
    diag       = ELEMENTS'(1) << cnt_q;
    trans_miss = 1'b0;
    for (int k = 0; k < ELEMENTS; k++) begin
      col_a[k]   = mat_q[k][cnt_q];
      trans_miss = trans_miss | (row_a[k] & (|(mat_q[k] & ~row_a)));
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    for (int r = 0; r < ELEMENTS; r++) begin
      mat_d[r] = mat_q[r];
    end
    case (state_q)
      StRun: begin
        if (!q_status_i.empty) begin
          if (cmd_i.set_bit) begin
            mat_d[row_idx][col_idx] = 1'b1;
          end
          if (cmd_i.last) begin
            state_d = StSweep;
            cnt_d   = '0;
            flags_d = '1;
          end
        end
      end
      StSweep: begin
        if (|(row_a & ~col_a)) begin
          flags_d.is_symmetric = 1'b0;
        end
        if (|(row_a & col_a & ~diag)) begin
          flags_d.is_antisymmetric = 1'b0;
        end
        if (trans_miss) begin
          flags_d.is_transitive = 1'b0;
        end
        if (cnt_q == IdxW'(ELEMENTS - 1)) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = flags_q;
          state_d     = StRun;
          for (int r = 0; r < ELEMENTS; r++) begin
            mat_d[r] = '0;
          end
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    flags_q <= flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < ELEMENTS; r++) begin
        mat_q[r] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      for (int r = 0; r < ELEMENTS; r++) begin
        mat_q[r] <= mat_d[r];
      end
    end
  end

endmodule

// ===== rtl/relation_property_checker.sv =====
// Pair items are taken at one per cycle while the queue is not full; each in-range
// valid pair and each item marked last goes through a two-entry queue. An item marked
// last starts a sweep over the matrix rows, row by row, and its result is then registered.
// The input keeps accepting pairs during the sweep until the queue fills.
// Reset clears the matrix, the queue pointers and the output valid flag at once.
module relation_property_checker import rpc_pkg::*; #(
  parameter int ELEMENTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;

  rpc_front #(
    .ELEMENTS(ELEMENTS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rpc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  rpc_back #(
    .ELEMENTS(ELEMENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== rtl/rpc_checker.sv =====
`include "assert_macros.svh"

module rpc_checker import rpc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input in_item_t  in_item_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input out_item_t out_item_o,
  input logic      out_stall_i
);

  logic [2:0] pending_q;
  logic       last_xfer;
  logic       out_xfer;

  assign last_xfer = in_valid_i & ~in_stall_o & in_item_i.last;
  assign out_xfer  = out_valid_o & ~out_stall_i;

  // Count of relations whose end has been accepted but whose result is not taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (last_xfer && !out_xfer) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_xfer && !last_xfer) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  `RPC_ASSERT_IN_RESET(a_no_result_in_reset, clk_i, rst_ni, !out_valid_o, "result during reset")
  `RPC_ASSERT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `RPC_ASSERT(a_result_has_source, clk_i, rst_ni, out_valid_o |-> pending_q != 3'd0, "result without a finished relation")
  `RPC_ASSERT(a_no_instant_verdict, clk_i, rst_ni, last_xfer && pending_q == 3'd0 |=> !out_valid_o, "verdict skipped the sweep")

endmodule

bind relation_property_checker rpc_checker u_rpc_checker (.*);
